### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared immediate-implication and next-cycle forms for concurrent checks
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define RCORC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RCORC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/rcorc_pkg.sv
// ----------------------------------------------------------------------------
// rcorc_pkg
// types and constants shared by the occupancy range cover block
// ----------------------------------------------------------------------------
`default_nettype none

package rcorc_pkg;

   localparam int MAX_SIDE_DEFAULT   = 1024;
   localparam int COUNT_BITS_DEFAULT = 16;

   localparam int IDX_BITS    = 10;
   localparam int SIZE_BITS   = 11;
   localparam int KIND_BITS   = 2;
   localparam int WORD_BITS   = 32;
   localparam int BIT_BITS    = 5;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [SIZE_BITS-1:0] BOARD_SIZE_RESET = 11'd1024;

   localparam logic [KIND_BITS-1:0] KIND_PLACE  = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_QUERY  = 2'd2;

   // classified transaction held in the queue
   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic                 row_ok;
      logic                 col_ok;
      logic [IDX_BITS-1:0]  row_lo;
      logic [IDX_BITS-1:0]  col_lo;
      logic [IDX_BITS-1:0]  row_hi;
      logic [IDX_BITS-1:0]  col_hi;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_stat_type;

endpackage

`default_nettype wire

### hdl/rcorc_req_if.sv
// ----------------------------------------------------------------------------
// rcorc_req_if
// request channel: place, remove and rectangle query transactions
// ----------------------------------------------------------------------------
`default_nettype none

interface rcorc_req_if;
   logic                                valid;
   logic                                ready;
   logic [rcorc_pkg::KIND_BITS-1:0]     kind;
   logic [rcorc_pkg::IDX_BITS-1:0]      row_index;
   logic [rcorc_pkg::IDX_BITS-1:0]      column_index;
   logic [rcorc_pkg::IDX_BITS-1:0]      row_end;
   logic [rcorc_pkg::IDX_BITS-1:0]      column_end;

   modport source (output valid, kind, row_index, column_index, row_end, column_end,
                   input ready);
   modport sink   (input valid, kind, row_index, column_index, row_end, column_end,
                   output ready);
endinterface

`default_nettype wire

### hdl/rcorc_rsp_if.sv
// ----------------------------------------------------------------------------
// rcorc_rsp_if
// response channel: coverage answer of one query
// ----------------------------------------------------------------------------
`default_nettype none

interface rcorc_rsp_if;
   logic valid;
   logic ready;
   logic covered;

   modport source (output valid, covered, input ready);
   modport sink   (input valid, covered, output ready);
endinterface

`default_nettype wire

### hdl/rcorc_csr_if.sv
// ----------------------------------------------------------------------------
// rcorc_csr_if
// configuration write channel for the board size register
// ----------------------------------------------------------------------------
`default_nettype none

interface rcorc_csr_if;
   logic                               valid;
   logic                               ready;
   logic [rcorc_pkg::SIZE_BITS-1:0]    board_size;

   modport source (output valid, board_size, input ready);
   modport sink   (input valid, board_size, output ready);
endinterface

`default_nettype wire

### hdl/row_column_occupancy_range_cover.sv
// ----------------------------------------------------------------------------
// row_column_occupancy_range_cover: per-row and per-column piece counts with range query
// place/remove: in the back end, counter and bitmap word read, then write back
// query: read then evaluate per 32-bit bitmap word spanned by the longer clipped range
//   (one bitmap read port per axis); a query with both ranges empty or off the board skips the scan
// reset: clearing pass over the counter and bitmap rams, requests held off meanwhile
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module row_column_occupancy_range_cover #(
   parameter int MAX_SIDE   = rcorc_pkg::MAX_SIDE_DEFAULT,
   parameter int COUNT_BITS = rcorc_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   rcorc_req_if.sink     req_chan,
   rcorc_rsp_if.source   rsp_chan,
   rcorc_csr_if.sink     csr_chan
);

   // board size register; the user must write it only while the block is idle, the block does not enforce it
   logic [rcorc_pkg::SIZE_BITS-1:0] board_size_ff, board_size_in;

   // queue head from the front end, status back from the back end
   rcorc_pkg::queue_type     queue;
   rcorc_pkg::back_stat_type back_stat;

   assign csr_chan.ready = 1'b1;
   assign board_size_in  = (csr_chan.valid && csr_chan.ready) ? csr_chan.board_size
                                                              : board_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         board_size_ff <= rcorc_pkg::BOARD_SIZE_RESET;
      end else begin
         board_size_ff <= board_size_in;
      end
   end

   // front end: takes each transaction, drops the unused kind, queues the rest
   rcorc_front #(
      .MAX_SIDE (MAX_SIDE)
   ) u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .stat  (back_stat),
      .head  (queue)
   );

   // back end: counter updates, bitmap upkeep, word-serial range scan, response register
   rcorc_back #(
      .MAX_SIDE   (MAX_SIDE),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .board_size (board_size_ff),
      .head       (queue),
      .stat       (back_stat),
      .rsp        (rsp_chan)
   );

   // no transaction is taken while the stores are being cleared
   `RCORC_ASSERT_IMP(a_clear_holds_req, clock, reset, back_stat.clearing, !req_chan.ready, "request accepted during clearing pass")
   // the queue stays empty through the clearing pass
   `RCORC_ASSERT_IMP(a_clear_queue_empty, clock, reset, back_stat.clearing, !queue.valid, "queue not empty during clearing pass")
   // the back end pops only a valid queue entry
   `RCORC_ASSERT_IMP(a_pop_has_entry, clock, reset, back_stat.pop, queue.valid, "pop from empty queue")
   // a configuration write lands in the register
   `RCORC_ASSERT_NXT(a_csr_loads, clock, reset, csr_chan.valid && csr_chan.ready && !reset, board_size_ff == $past(csr_chan.board_size), "board size write lost")

endmodule

`default_nettype wire

### hdl/rcorc_ram.sv
// ----------------------------------------------------------------------------
// rcorc_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rcorc_ram #(
   parameter int WIDTH     = 1,
   parameter int DEPTH     = 2,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output      logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/rcorc_front.sv
// ----------------------------------------------------------------------------
// rcorc_front
// accepts request transactions, classifies them and queues them for the back
// ----------------------------------------------------------------------------
`default_nettype none

module rcorc_front #(
   parameter int MAX_SIDE = rcorc_pkg::MAX_SIDE_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   rcorc_req_if.sink                     req,
   input  wire rcorc_pkg::back_stat_type stat,
   output      rcorc_pkg::queue_type     head
);

   localparam int QP  = (rcorc_pkg::QUEUE_DEPTH > 1) ? $clog2(rcorc_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT = $clog2(rcorc_pkg::QUEUE_DEPTH + 1);

   rcorc_pkg::item_type q_ff [rcorc_pkg::QUEUE_DEPTH];
   logic [QP-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QP-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT-1:0]      count_ff, count_in;

   rcorc_pkg::item_type item;
   logic                known;
   logic                push;
   logic                pop;

   // classify: kind and whether each index lands inside the counter store
   always_comb begin
      item.kind   = req.kind;
      item.row_ok = 32'(req.row_index) < 32'(MAX_SIDE);
      item.col_ok = 32'(req.column_index) < 32'(MAX_SIDE);
      item.row_lo = req.row_index;
      item.col_lo = req.column_index;
      item.row_hi = req.row_end;
      item.col_hi = req.column_end;
   end

   assign known     = (req.kind == rcorc_pkg::KIND_PLACE) ||
                      (req.kind == rcorc_pkg::KIND_REMOVE) ||
                      (req.kind == rcorc_pkg::KIND_QUERY);
   assign req.ready = !stat.clearing && (count_ff != CNT'(rcorc_pkg::QUEUE_DEPTH));
   // unused kind is taken and dropped here
   assign push      = req.valid && req.ready && known;
   assign pop       = stat.pop;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QP'(rcorc_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QP'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QP'(rcorc_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QP'(1);
      end
      count_in = count_ff + CNT'(push) - CNT'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.item  = q_ff[rd_ptr_ff];

endmodule

`default_nettype wire

### hdl/rcorc_back.sv
// ----------------------------------------------------------------------------
// rcorc_back
// counter read-modify-write, occupancy bitmap upkeep and word-serial range scan
// ----------------------------------------------------------------------------
`default_nettype none

module rcorc_back #(
   parameter int MAX_SIDE   = rcorc_pkg::MAX_SIDE_DEFAULT,
   parameter int COUNT_BITS = rcorc_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic [rcorc_pkg::SIZE_BITS-1:0]    board_size,
   input  wire rcorc_pkg::queue_type               head,
   output      rcorc_pkg::back_stat_type           stat,
   rcorc_rsp_if.source                             rsp
);

   localparam int AW    = $clog2(MAX_SIDE);
   localparam int WORDS = (MAX_SIDE + rcorc_pkg::WORD_BITS - 1) / rcorc_pkg::WORD_BITS;
   localparam int WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int PW    = ((AW > rcorc_pkg::SIZE_BITS) ? AW : rcorc_pkg::SIZE_BITS) + 2;

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,
      ST_IDLE   = 6'b000010,
      ST_UPDATE = 6'b000100,
      ST_READ   = 6'b001000,
      ST_EVAL   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   logic [AW-1:0]       clr_addr_ff, clr_addr_in;
   rcorc_pkg::item_type item_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_covered_ff, rsp_covered_in;

   logic [PW-1:0] size_eff;
   logic          clearing;
   logic          clr_in_words;
   logic          pop;
   logic          load_rsp;

   logic [PW-1:0] h_lo [2];
   logic [PW-1:0] h_hi [2];
   logic [PW-1:0] i_lo [2];
   logic [PW-1:0] i_hi [2];
   logic          i_ok [2];
   logic          start_act [2];
   logic          cont_act  [2];
   logic          full_q    [2];

   assign size_eff = (PW'(board_size) < PW'(MAX_SIDE)) ? PW'(board_size) : PW'(MAX_SIDE);

   assign clearing     = (state_ff == ST_CLEAR);
   assign clr_in_words = ({1'b0, clr_addr_ff} < (AW + 1)'(WORDS));
   assign pop          = (state_ff == ST_IDLE) && head.valid;
   assign load_rsp     = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);

   assign h_lo[0] = PW'(head.item.row_lo);
   assign h_lo[1] = PW'(head.item.col_lo);
   assign h_hi[0] = PW'(head.item.row_hi);
   assign h_hi[1] = PW'(head.item.col_hi);
   assign i_lo[0] = PW'(item_ff.row_lo);
   assign i_lo[1] = PW'(item_ff.col_lo);
   assign i_hi[0] = PW'(item_ff.row_hi);
   assign i_hi[1] = PW'(item_ff.col_hi);
   assign i_ok[0] = item_ff.row_ok;
   assign i_ok[1] = item_ff.col_ok;

   // axis 0 is rows, axis 1 is columns
   for (genvar a = 0; a < 2; a++) begin : g_axis
      logic [COUNT_BITS-1:0]          cnt_rd, cnt_new;
      logic [rcorc_pkg::WORD_BITS-1:0] map_rd, map_set, need;
      logic [PW-1:0]                  h_word_p, i_word_p, base_p, next_p;
      logic                           cnt_we, map_we, fail, still;
      logic [AW-1:0]                  cnt_wa;
      logic [WAW-1:0]                 map_wa, map_ra;
      logic [COUNT_BITS-1:0]          cnt_wd;
      logic [rcorc_pkg::WORD_BITS-1:0] map_wd;

      logic [WAW-1:0] word_ff, word_in;
      logic           active_ff, active_in;
      logic           full_ff, full_in;

      assign h_word_p = h_lo[a] >> rcorc_pkg::BIT_BITS;
      assign i_word_p = i_lo[a] >> rcorc_pkg::BIT_BITS;

      // saturating count step
      always_comb begin
         if (item_ff.kind == rcorc_pkg::KIND_PLACE) begin
            cnt_new = (cnt_rd != '1) ? cnt_rd + COUNT_BITS'(1) : cnt_rd;
         end else begin
            cnt_new = (cnt_rd != '0) ? cnt_rd - COUNT_BITS'(1) : cnt_rd;
         end
         map_set = map_rd;
         map_set[i_lo[a][rcorc_pkg::BIT_BITS-1:0]] = (cnt_new != '0);
      end

      assign cnt_we = clearing || ((state_ff == ST_UPDATE) && i_ok[a]);
      assign cnt_wa = clearing ? clr_addr_ff : i_lo[a][AW-1:0];
      assign cnt_wd = clearing ? '0 : cnt_new;
      assign map_we = (clearing && clr_in_words) || ((state_ff == ST_UPDATE) && i_ok[a]);
      assign map_wa = clearing ? clr_addr_ff[WAW-1:0] : i_word_p[WAW-1:0];
      assign map_wd = clearing ? '0 : map_set;
      assign map_ra = (state_ff == ST_IDLE) ? h_word_p[WAW-1:0] : word_ff;

      rcorc_ram #(
         .WIDTH (COUNT_BITS),
         .DEPTH (MAX_SIDE)
      ) u_cnt_ram (
         .clock   (clock),
         .wr_en   (cnt_we),
         .wr_addr (cnt_wa),
         .wr_data (cnt_wd),
         .rd_addr (h_lo[a][AW-1:0]),
         .rd_data (cnt_rd)
      );

      rcorc_ram #(
         .WIDTH (rcorc_pkg::WORD_BITS),
         .DEPTH (WORDS)
      ) u_map_ram (
         .clock   (clock),
         .wr_en   (map_we),
         .wr_addr (map_wa),
         .wr_data (map_wd),
         .rd_addr (map_ra),
         .rd_data (map_rd)
      );

      // positions of the current word that the query must see occupied
      assign base_p = PW'(word_ff) << rcorc_pkg::BIT_BITS;
      always_comb begin
         logic [PW-1:0] p;
         for (int b = 0; b < rcorc_pkg::WORD_BITS; b++) begin
            p       = base_p | PW'(b);
            need[b] = (p >= i_lo[a]) && (p <= i_hi[a]) && (p < size_eff);
         end
      end

      assign fail   = |(need & ~map_rd);
      assign next_p = base_p + PW'(rcorc_pkg::WORD_BITS);
      assign still  = (next_p <= i_hi[a]) && (next_p < size_eff);

      assign start_act[a] = (h_lo[a] <= h_hi[a]) && (h_lo[a] < size_eff);
      assign cont_act[a]  = active_ff && still;
      assign full_q[a]    = full_ff;

      always_comb begin
         word_in   = word_ff;
         active_in = active_ff;
         full_in   = full_ff;
         if (pop && (head.item.kind == rcorc_pkg::KIND_QUERY)) begin
            word_in   = h_word_p[WAW-1:0];
            active_in = start_act[a];
            full_in   = 1'b1;
         end else if ((state_ff == ST_EVAL) && active_ff) begin
            full_in   = full_ff && !fail;
            active_in = still;
            if (still) begin
               word_in = word_ff + WAW'(1);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            active_ff <= 1'b0;
            full_ff   <= 1'b0;
         end else begin
            active_ff <= active_in;
            full_ff   <= full_in;
         end
      end

      always_ff @(posedge clock) begin
         word_ff <= word_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      clr_addr_in    = clr_addr_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_covered_in = rsp_covered_ff;
      if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(MAX_SIDE - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (head.valid) begin
               if (head.item.kind == rcorc_pkg::KIND_QUERY) begin
                  state_in = (start_act[0] || start_act[1]) ? ST_READ : ST_DONE;
               end else begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: state_in = ST_IDLE;
         ST_READ:   state_in = ST_EVAL;
         ST_EVAL: begin
            state_in = (cont_act[0] || cont_act[1]) ? ST_READ : ST_DONE;
         end
         ST_DONE: begin
            if (load_rsp) begin
               rsp_valid_in   = 1'b1;
               rsp_covered_in = full_q[0] || full_q[1];
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_covered_ff <= rsp_covered_in;
      if (pop) begin
         item_ff <= head.item;
      end
   end

   assign stat.pop      = pop;
   assign stat.clearing = clearing;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.covered   = rsp_covered_ff;

endmodule

`default_nettype wire

### test/row_column_occupancy_range_cover_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_column_occupancy_range_cover_tb
// drives place, remove and rectangle query transactions into the occupancy
// cover block and tracks per-row and per-column piece counts alongside it;
// each covered answer is compared against the tracked occupancy, across
// several board sizes, random stalls on both channels and one long hold-off
// ----------------------------------------------------------------------------
module row_column_occupancy_range_cover_tb;

   localparam int SIDE        = rcorc_pkg::MAX_SIDE_DEFAULT;
   localparam int COUNT_BITS  = rcorc_pkg::COUNT_BITS_DEFAULT;
   localparam logic [rcorc_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;
   // slowest query scans every bitmap word; place/remove leave nothing to wait for
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES  = 100;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_ITEMS   = 250;
   localparam int PILE_DEPTH    = 40;
   // about 2100 transactions at up to the slowest query time plus response
   // stalls, the clearing pass and the long hold-off, then taken several
   // times over
   localparam int CYCLE_LIMIT   = 1_000_000;

   typedef struct packed {
      logic [rcorc_pkg::KIND_BITS-1:0] kind;
      logic [rcorc_pkg::IDX_BITS-1:0]  row_index;
      logic [rcorc_pkg::IDX_BITS-1:0]  column_index;
      logic [rcorc_pkg::IDX_BITS-1:0]  row_end;
      logic [rcorc_pkg::IDX_BITS-1:0]  column_end;
   } grid_request_type;

   logic clock = 1'b0;
   logic reset;

   rcorc_req_if req_chan ();
   rcorc_rsp_if rsp_chan ();
   rcorc_csr_if csr_chan ();

   row_column_occupancy_range_cover dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #6 clock = ~clock;

   // tracked board state
   logic [COUNT_BITS-1:0]           row_pieces    [SIDE];
   logic [COUNT_BITS-1:0]           column_pieces [SIDE];
   logic [rcorc_pkg::SIZE_BITS-1:0] board_side;

   grid_request_type pending_requests [$];
   bit               covered_expected [$];
   grid_request_type offered_request;
   longint           requests_issued = 0;
   longint           requests_taken  = 0;
   int               failures        = 0;
   int               send_idle_pct   = 0;
   int               recv_idle_pct   = 0;
   logic             hold_arm        = 1'b0;
   logic             hold_done;
   int               hold_left;
   int               cycle_count     = 0;

   // board sizes of the random phases: tiny, zero, oversized, just over the
   // store, small, odd, large and the full store
   logic [rcorc_pkg::SIZE_BITS-1:0] size_plan [8] = '{11'd1, 11'd0, 11'd2047, 11'd1025,
                                                     11'd2, 11'd37, 11'd700, 11'd1024};

   // true when every in-board index of lo..hi is occupied; empty range is true
   function automatic bit span_occupied(input bit on_rows, input int lo, input int hi);
      int limit;
      limit = (board_side > SIDE) ? SIDE : int'(board_side);
      for (int i = lo; i <= hi; i++) begin
         if (i < limit) begin
            if (on_rows ? (row_pieces[i] == 0) : (column_pieces[i] == 0))
               return 1'b0;
         end
      end
      return 1'b1;
   endfunction

   // apply one accepted transaction to the tracked board
   function automatic void advance_grid(input grid_request_type r);
      case (r.kind)
         rcorc_pkg::KIND_PLACE: begin
            if (row_pieces[r.row_index] != '1)
               row_pieces[r.row_index]++;
            if (column_pieces[r.column_index] != '1)
               column_pieces[r.column_index]++;
         end
         rcorc_pkg::KIND_REMOVE: begin
            if (row_pieces[r.row_index] != 0)
               row_pieces[r.row_index]--;
            if (column_pieces[r.column_index] != 0)
               column_pieces[r.column_index]--;
         end
         rcorc_pkg::KIND_QUERY: begin
            covered_expected = {covered_expected,
                                bit'(span_occupied(1'b1, r.row_index, r.row_end) ||
                                     span_occupied(1'b0, r.column_index, r.column_end))};
         end
         default: ;
      endcase
   endfunction

   task automatic queue_request(input logic [rcorc_pkg::KIND_BITS-1:0] kind,
                                input int row_index, input int column_index,
                                input int row_end, input int column_end);
      grid_request_type r;
      r.kind         = kind;
      r.row_index    = row_index[rcorc_pkg::IDX_BITS-1:0];
      r.column_index = column_index[rcorc_pkg::IDX_BITS-1:0];
      r.row_end      = row_end[rcorc_pkg::IDX_BITS-1:0];
      r.column_end   = column_end[rcorc_pkg::IDX_BITS-1:0];
      pending_requests = {pending_requests, r};
      requests_issued++;
   endtask

   // mostly a hot window near zero so counts build up, some near the board
   // edge, the rest anywhere
   function automatic int pick_index();
      int sel;
      int side;
      sel  = $urandom_range(0, 99);
      side = (board_side > SIDE) ? SIDE : int'(board_side);
      if (sel < 55)
         return $urandom_range(0, 47);
      if (sel < 70)
         return (side > 2 ? side - 2 : 0) + $urandom_range(0, 3);
      return $urandom_range(0, SIDE - 1);
   endfunction

   function automatic int pick_end(input int lo);
      int sel;
      int hi;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
         hi = lo + $urandom_range(0, 48);
         return (hi > SIDE - 1) ? SIDE - 1 : hi;
      end
      // empty range: end below start
      if (sel < 82 && lo > 0)
         return $urandom_range(0, lo - 1);
      return $urandom_range(0, SIDE - 1);
   endfunction

   task automatic queue_random_request();
      int sel;
      int r0;
      int c0;
      sel = $urandom_range(0, 99);
      r0  = pick_index();
      c0  = pick_index();
      if (sel < 40)
         queue_request(rcorc_pkg::KIND_PLACE, r0, c0, $urandom_range(0, SIDE - 1),
                       $urandom_range(0, SIDE - 1));
      else if (sel < 62)
         queue_request(rcorc_pkg::KIND_REMOVE, r0, c0, $urandom_range(0, SIDE - 1),
                       $urandom_range(0, SIDE - 1));
      else if (sel < 95)
         queue_request(rcorc_pkg::KIND_QUERY, r0, c0, pick_end(r0), pick_end(c0));
      else
         queue_request(KIND_UNUSED, $urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
                       $urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1));
   endtask

   // all transactions taken, all answers back, then let the back end drain
   task automatic wait_quiet();
      while (requests_taken != requests_issued || covered_expected.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_board_size(input logic [rcorc_pkg::SIZE_BITS-1:0] value);
      wait_quiet();
      @(posedge clock);
      csr_chan.valid      <= 1'b1;
      csr_chan.board_size <= value;
      do
         @(posedge clock);
      while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      board_side = value;
   endtask

   // request driver: offers the next pending transaction, tracks acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            advance_grid(offered_request);
            requests_taken++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               offered_request        = pending_requests.pop_front();
               req_chan.valid        <= 1'b1;
               req_chan.kind         <= offered_request.kind;
               req_chan.row_index    <= offered_request.row_index;
               req_chan.column_index <= offered_request.column_index;
               req_chan.row_end      <= offered_request.row_end;
               req_chan.column_end   <= offered_request.column_end;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, armed once, so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_arm && !hold_done) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response monitor: checks each covered answer against the oldest expectation
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (covered_expected.size() == 0) begin
               $error("covered: no result expected, actual %0b", rsp_chan.covered);
               failures++;
            end else if (rsp_chan.covered !== covered_expected[0]) begin
               $error("covered: expected %0b, actual %0b", covered_expected[0],
                      rsp_chan.covered);
               failures++;
               void'(covered_expected.pop_front());
            end else begin
               void'(covered_expected.pop_front());
            end
         end
         rsp_chan.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("row_column_occupancy_range_cover_tb failed");
         $finish;
      end
   end

   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.kind         = rcorc_pkg::KIND_PLACE;
      req_chan.row_index    = '0;
      req_chan.column_index = '0;
      req_chan.row_end      = '0;
      req_chan.column_end   = '0;
      rsp_chan.ready        = 1'b0;
      csr_chan.valid        = 1'b0;
      csr_chan.board_size   = '0;
      board_side            = rcorc_pkg::BOARD_SIZE_RESET;
      for (int i = 0; i < SIDE; i++) begin
         row_pieces[i]    = '0;
         column_pieces[i] = '0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed part on the full board, sender 26% / receiver 74% idle
      send_idle_pct = 26;
      recv_idle_pct = 74;
      write_board_size(rcorc_pkg::BOARD_SIZE_RESET);
      // empty board, whole rectangle
      queue_request(rcorc_pkg::KIND_QUERY, 0, 0, SIDE - 1, SIDE - 1);
      // empty row range, empty column range
      queue_request(rcorc_pkg::KIND_QUERY, 5, 0, 4, SIDE - 1);
      queue_request(rcorc_pkg::KIND_QUERY, 0, 10, SIDE - 1, 9);
      // corners and a neighbor
      queue_request(rcorc_pkg::KIND_PLACE, 0, 0, 0, 0);
      queue_request(rcorc_pkg::KIND_PLACE, SIDE - 1, SIDE - 1, SIDE - 1, SIDE - 1);
      queue_request(rcorc_pkg::KIND_PLACE, 1, 1, 0, 0);
      queue_request(rcorc_pkg::KIND_QUERY, 0, 2, 1, 2);
      queue_request(rcorc_pkg::KIND_QUERY, 0, 0, 2, 1);
      queue_request(rcorc_pkg::KIND_QUERY, 0, 0, 2, 2);
      queue_request(rcorc_pkg::KIND_QUERY, SIDE - 1, 500, SIDE - 1, 500);
      // remove down to zero, then remove of an empty counter
      queue_request(rcorc_pkg::KIND_REMOVE, 1, 1, SIDE - 1, SIDE - 1);
      queue_request(rcorc_pkg::KIND_QUERY, 0, 0, 1, 1);
      queue_request(rcorc_pkg::KIND_REMOVE, 1, 1, 0, 0);
      queue_request(rcorc_pkg::KIND_QUERY, 0, 0, 1, 1);
      queue_request(rcorc_pkg::KIND_PLACE, 1, 1, 0, 0);
      queue_request(rcorc_pkg::KIND_QUERY, 0, 0, 1, 1);
      // unused kind with every bit set changes nothing
      queue_request(KIND_UNUSED, SIDE - 1, SIDE - 1, SIDE - 1, SIDE - 1);
      queue_request(rcorc_pkg::KIND_REMOVE, SIDE - 1, SIDE - 1, 0, 0);
      queue_request(rcorc_pkg::KIND_QUERY, SIDE - 1, SIDE - 1, SIDE - 1, SIDE - 1);

      // pile-up on row 3 / column 3 and back down to zero
      wait_quiet();
      repeat (PILE_DEPTH) queue_request(rcorc_pkg::KIND_PLACE, 3, 3, 0, 0);
      queue_request(rcorc_pkg::KIND_QUERY, 3, 1000, 3, 1000);
      repeat (PILE_DEPTH - 1) queue_request(rcorc_pkg::KIND_REMOVE, 3, 3, 0, 0);
      queue_request(rcorc_pkg::KIND_QUERY, 3, 1000, 3, 1000);
      queue_request(rcorc_pkg::KIND_REMOVE, 3, 3, 0, 0);
      queue_request(rcorc_pkg::KIND_QUERY, 3, 1000, 3, 1000);
      // remove at zero must not wrap
      queue_request(rcorc_pkg::KIND_REMOVE, 3, 3, 0, 0);
      queue_request(rcorc_pkg::KIND_PLACE, 3, 3, 0, 0);
      queue_request(rcorc_pkg::KIND_QUERY, 3, 1000, 3, 1000);
      queue_request(rcorc_pkg::KIND_REMOVE, 3, 3, 0, 0);

      // random phases, one board size each
      for (int phase = 0; phase < 8; phase++) begin
         write_board_size(size_plan[phase]);
         if (phase < 3) begin
            send_idle_pct = 26;
            recv_idle_pct = 74;
         end else if (phase < 6) begin
            send_idle_pct = 74;
            recv_idle_pct = 26;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         repeat (PHASE_ITEMS) queue_random_request();
         if (phase == 6)
            hold_arm <= 1'b1;
      end

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (covered_expected.size() != 0) begin
         $error("covered: %0d results never arrived", covered_expected.size());
         failures++;
      end
      if (failures == 0) begin
         $display("row_column_occupancy_range_cover_tb passed");
      end else begin
         $display("row_column_occupancy_range_cover_tb failed");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/rcorc_pkg.sv
hdl/rcorc_req_if.sv
hdl/rcorc_rsp_if.sv
hdl/rcorc_csr_if.sv
hdl/rcorc_ram.sv
hdl/rcorc_front.sv
hdl/rcorc_back.sv
hdl/row_column_occupancy_range_cover.sv
test/row_column_occupancy_range_cover_tb.sv
